### hw/rtl/sawcl_pkg.sv
// Shared types and constants for the set-associative write-back cache.
// No dependencies.
package sawcl_pkg;

	localparam int unsigned DefWays      = 8;
	localparam int unsigned DefSets      = 256;
	localparam int unsigned DefLineBytes = 32;

	typedef enum logic [1:0] {
		OP_READ       = 2'd0,
		OP_WRITE      = 2'd1,
		OP_FILL_READ  = 2'd2,
		OP_FILL_WRITE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_READ_HIT  = 3'd0,
		KIND_WRITE_HIT = 3'd1,
		KIND_MISS      = 3'd2,
		KIND_WB_WORD   = 3'd3,
		KIND_FILLED    = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_ACC,
		ST_ACC_OUT,
		ST_MISS_OUT,
		ST_WB_RD,
		ST_WB_OUT,
		ST_INSTALL,
		ST_FILL_OUT
	} state_t;

endpackage

### hw/rtl/set_assoc_writeback_cache_lru_unit.sv
// Set-associative write-back cache with LRU ranks, one sequencer over set memories.
// Depends on sawcl_pkg.
//
// After reset the block sweeps the per-set valid/dirty/rank memory, one set a cycle
// with req_stall high. Each request is then handled alone by a small sequencer
// around single-port set and word memories: a hit goes through set read, way
// compare, word access and result beat; a miss through set read, way compare and
// miss beat; a non-final fill word is buffered and gives no beat; a final fill word
// installs the line and gives its beat, after a dirty victim is written back word
// by word through the one data port. Results leave through an output register; a
// stalled result holds the sequencer.
module set_assoc_writeback_cache_lru_unit #(
	parameter int unsigned WAYS       = sawcl_pkg::DefWays,
	parameter int unsigned SETS       = sawcl_pkg::DefSets,
	parameter int unsigned LINE_BYTES = sawcl_pkg::DefLineBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [3:0]  request_id,
	input  logic [31:0] data,
	input  logic [31:0] merge_value,
	input  logic [2:0]  word_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  kind,
	output logic [31:0] out_address,
	output logic [31:0] out_data,
	output logic [3:0]  out_request_id,
	output logic        miss_is_write,
	output logic        last
);

	localparam int unsigned WORDS = LINE_BYTES / 4;
	localparam int unsigned OB    = $clog2(LINE_BYTES);
	localparam int unsigned SB    = $clog2(SETS);
	localparam int unsigned WB    = $clog2(WORDS);
	localparam int unsigned YB    = $clog2(WAYS);
	localparam int unsigned RW    = $clog2(WAYS);
	localparam int unsigned TW    = 32 - OB - SB;
	localparam int unsigned DA    = SB + YB + WB;

	sawcl_pkg::state_t state_q, state_d;

	// request registers
	sawcl_pkg::op_t     op_q;
	logic [31:0]        addr_q;
	logic [3:0]         rid_q;
	logic [31:0]        data_q;
	logic [31:0]        merge_q;
	logic               final_q;

	logic [SB-1:0]      set_q;
	logic [SB-1:0]      clr_q;
	logic [WB-1:0]      cnt_q;
	logic [YB-1:0]      way_q;

	logic [31:0]        fbuf_q [WORDS];

	// set memories
	logic [WAYS-1:0]    vmem [SETS];
	logic [WAYS-1:0]    dmem [SETS];
	logic [WAYS*RW-1:0] rmem [SETS];
	logic [WAYS*TW-1:0] tmem [SETS];
	logic [WAYS-1:0]    vrd_q, drd_q;
	logic [WAYS*RW-1:0] rrd_q;
	logic [WAYS*TW-1:0] trd_q;

	logic [31:0]        wmem [(SETS << YB) * WORDS];
	logic [31:0]        wrd_q;

	logic               accept, ofree;
	logic [SB-1:0]      in_set;
	logic [TW-1:0]      tag_q;
	logic [WB-1:0]      word_q;

	assign accept  = req_valid && !req_stall;
	assign ofree   = !rsp_valid || !rsp_stall;
	assign in_set  = address[OB +: SB];
	assign tag_q   = addr_q[31 -: TW];
	assign word_q  = addr_q[2 +: WB];

	// way compare and victim choice
	logic              hit_c;
	logic [YB-1:0]     hway_c, vict_c;
	logic              found_inv, found_r0;
	logic [YB-1:0]     inv_way, r0_way;

	always_comb begin
		hit_c     = 1'b0;
		hway_c    = '0;
		found_inv = 1'b0;
		inv_way   = '0;
		found_r0  = 1'b0;
		r0_way    = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (vrd_q[i] && trd_q[i*TW +: TW] == tag_q) begin
				hit_c  = 1'b1;
				hway_c = YB'(i);
			end
			if (!vrd_q[i]) begin
				found_inv = 1'b1;
				inv_way   = YB'(i);
			end
			if (rrd_q[i*RW +: RW] == '0) begin
				found_r0 = 1'b1;
				r0_way   = YB'(i);
			end
		end
		priority if (hit_c)     vict_c = hway_c;
		else if (found_inv)     vict_c = inv_way;
		else if (found_r0)      vict_c = r0_way;
		else                    vict_c = '0;
	end

	// recency and flag update for way_q
	logic [WAYS*RW-1:0] rnew;
	logic [WAYS-1:0]    vnew, dnew;
	logic [RW-1:0]      rsel;

	always_comb begin
		rsel = rrd_q[way_q*RW +: RW];
		vnew = vrd_q;
		dnew = drd_q;
		for (int i = 0; i < WAYS; i++) begin
			rnew[i*RW +: RW] = (rrd_q[i*RW +: RW] > rsel) ?
				rrd_q[i*RW +: RW] - RW'(1) : rrd_q[i*RW +: RW];
		end
		rnew[way_q*RW +: RW] = RW'(WAYS - 1);
		if (state_q == sawcl_pkg::ST_ACC) begin
			if (op_q == sawcl_pkg::OP_WRITE) dnew[way_q] = 1'b1;
		end else begin
			vnew[way_q] = 1'b1;
			dnew[way_q] = (op_q == sawcl_pkg::OP_FILL_WRITE);
		end
	end

	logic          last_cnt;
	assign last_cnt = (cnt_q == WB'(WORDS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sawcl_pkg::ST_CLEAR:    if (clr_q == SB'(SETS - 1)) state_d = sawcl_pkg::ST_IDLE;
			sawcl_pkg::ST_IDLE:     if (accept) state_d = sawcl_pkg::ST_LOOK;
			sawcl_pkg::ST_LOOK: begin
				if (op_q == sawcl_pkg::OP_READ || op_q == sawcl_pkg::OP_WRITE)
					state_d = hit_c ? sawcl_pkg::ST_ACC : sawcl_pkg::ST_MISS_OUT;
				else if (!final_q)
					state_d = sawcl_pkg::ST_IDLE;
				else if (vrd_q[vict_c] && drd_q[vict_c])
					state_d = sawcl_pkg::ST_WB_RD;
				else
					state_d = sawcl_pkg::ST_INSTALL;
			end
			sawcl_pkg::ST_ACC:      state_d = sawcl_pkg::ST_ACC_OUT;
			sawcl_pkg::ST_ACC_OUT,
			sawcl_pkg::ST_MISS_OUT,
			sawcl_pkg::ST_FILL_OUT: if (ofree) state_d = sawcl_pkg::ST_IDLE;
			sawcl_pkg::ST_WB_RD:    state_d = sawcl_pkg::ST_WB_OUT;
			sawcl_pkg::ST_WB_OUT: begin
				if (ofree) state_d = last_cnt ? sawcl_pkg::ST_INSTALL : sawcl_pkg::ST_WB_RD;
			end
			sawcl_pkg::ST_INSTALL:  if (last_cnt) state_d = sawcl_pkg::ST_FILL_OUT;
			default:                state_d = sawcl_pkg::ST_CLEAR;
		endcase
	end

	// datapath control
	logic          w_we, w_re, meta_we, tag_we, ld_out;
	logic [DA-1:0] w_addr;
	logic [31:0]   w_wdata;
	logic [2:0]    o_kind;
	logic [31:0]   o_addr, o_data;
	logic          o_mw, o_last;

	always_comb begin
		w_we    = 1'b0;
		w_re    = 1'b0;
		meta_we = 1'b0;
		tag_we  = 1'b0;
		ld_out  = 1'b0;
		w_addr  = {set_q, way_q, word_q};
		w_wdata = data_q;
		o_kind  = sawcl_pkg::KIND_MISS;
		o_addr  = addr_q;
		o_data  = '0;
		o_mw    = 1'b0;
		o_last  = 1'b1;
		unique case (state_q)
			sawcl_pkg::ST_ACC: begin
				w_re    = 1'b1;
				w_we    = (op_q == sawcl_pkg::OP_WRITE);
				meta_we = 1'b1;
			end
			sawcl_pkg::ST_ACC_OUT: begin
				ld_out = ofree;
				o_kind = (op_q == sawcl_pkg::OP_WRITE) ? sawcl_pkg::KIND_WRITE_HIT
					: sawcl_pkg::KIND_READ_HIT;
				o_data = (op_q == sawcl_pkg::OP_WRITE) ? data_q : wrd_q;
			end
			sawcl_pkg::ST_MISS_OUT: begin
				ld_out = ofree;
				o_mw   = (op_q == sawcl_pkg::OP_WRITE);
			end
			sawcl_pkg::ST_WB_RD: begin
				w_re   = 1'b1;
				w_addr = {set_q, way_q, cnt_q};
			end
			sawcl_pkg::ST_WB_OUT: begin
				ld_out = ofree;
				o_kind = sawcl_pkg::KIND_WB_WORD;
				o_addr = {trd_q[way_q*TW +: TW], set_q, cnt_q, 2'b00};
				o_data = wrd_q;
				o_last = 1'b0;
			end
			sawcl_pkg::ST_INSTALL: begin
				w_we    = 1'b1;
				w_addr  = {set_q, way_q, cnt_q};
				w_wdata = (op_q == sawcl_pkg::OP_FILL_WRITE && cnt_q == word_q) ?
					merge_q : fbuf_q[cnt_q];
				meta_we = last_cnt;
				tag_we  = last_cnt;
			end
			sawcl_pkg::ST_FILL_OUT: begin
				ld_out = ofree;
				o_kind = sawcl_pkg::KIND_FILLED;
				o_addr = {addr_q[31:OB], OB'(0)};
				o_mw   = (op_q == sawcl_pkg::OP_FILL_WRITE);
				o_data = o_mw ? merge_q : fbuf_q[word_q];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sawcl_pkg::ST_CLEAR;
			clr_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sawcl_pkg::ST_CLEAR) clr_q <= clr_q + SB'(1);
			if (ld_out) rsp_valid <= 1'b1;
			else if (!rsp_stall) rsp_valid <= 1'b0;
		end
	end

	assign req_stall = (state_q != sawcl_pkg::ST_IDLE);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= sawcl_pkg::op_t'(operation);
			addr_q  <= address;
			rid_q   <= request_id;
			data_q  <= data;
			merge_q <= merge_value;
			set_q   <= in_set;
			final_q <= (word_index == 3'(WORDS - 1));
			if (operation[1]) fbuf_q[WB'(word_index)] <= data;
		end
		if (state_q == sawcl_pkg::ST_LOOK) begin
			way_q <= (op_q[1]) ? vict_c : hway_c;
			cnt_q <= '0;
		end else if ((state_q == sawcl_pkg::ST_WB_OUT && ofree) ||
			state_q == sawcl_pkg::ST_INSTALL) begin
			cnt_q <= last_cnt ? '0 : cnt_q + WB'(1);
		end
		if (ld_out) begin
			kind           <= o_kind;
			out_address    <= o_addr;
			out_data       <= o_data;
			out_request_id <= rid_q;
			miss_is_write  <= o_mw;
			last           <= o_last;
		end
	end

	// set memories: one address per cycle
	always_ff @(posedge clk) begin
		if (state_q == sawcl_pkg::ST_CLEAR) begin
			vmem[clr_q] <= '0;
			dmem[clr_q] <= '0;
			rmem[clr_q] <= '0;
		end else if (meta_we) begin
			vmem[set_q] <= vnew;
			dmem[set_q] <= dnew;
			rmem[set_q] <= rnew;
		end else if (accept) begin
			vrd_q <= vmem[in_set];
			drd_q <= dmem[in_set];
			rrd_q <= rmem[in_set];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tmem[set_q][way_q*TW +: TW] <= tag_q;
		end else if (accept) begin
			trd_q <= tmem[in_set];
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_addr] <= w_wdata;
		if (w_re) wrd_q <= wmem[w_addr];
	end

endmodule

### tb/sawcl_scoreboard.sv
// Scoreboard for the set-associative write-back cache: watches both channels,
// predicts each result beat from its own copy of the cache state and compares.
// Depends on sawcl_pkg.
module sawcl_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [3:0]  request_id,
	input  logic [31:0] data,
	input  logic [31:0] merge_value,
	input  logic [2:0]  word_index,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] out_address,
	input  logic [31:0] out_data,
	input  logic [3:0]  out_request_id,
	input  logic        miss_is_write,
	input  logic        last,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NWAYS  = sawcl_pkg::DefWays;
	localparam int unsigned NSETS  = sawcl_pkg::DefSets;
	localparam int unsigned NWORDS = sawcl_pkg::DefLineBytes / 4;

	typedef struct packed {
		sawcl_pkg::kind_t kind;
		logic [31:0]      addr;
		logic [31:0]      word;
		logic [3:0]       rid;
		logic             mw;
		logic             lst;
	} beat_t;

	beat_t       expected_beats[$];
	logic [18:0] tag_mem[NSETS*NWAYS];
	bit          valid_mem[NSETS*NWAYS];
	bit          dirty_mem[NSETS*NWAYS];
	bit [2:0]    rank_mem[NSETS*NWAYS];
	logic [31:0] word_mem[NSETS*NWAYS*NWORDS];
	logic [31:0] fill_words[NWORDS];

	function automatic beat_t mk(sawcl_pkg::kind_t k, logic [31:0] a, logic [31:0] d,
			logic [3:0] r, logic m, logic l);
		beat_t b;
		b.kind = k; b.addr = a; b.word = d; b.rid = r; b.mw = m; b.lst = l;
		return b;
	endfunction

	function automatic void promote(int unsigned base, int unsigned way);
		bit [2:0] r;
		r = rank_mem[base+way];
		for (int i = 0; i < NWAYS; i++)
			if (rank_mem[base+i] > r) rank_mem[base+i]--;
		rank_mem[base+way] = 3'(NWAYS - 1);
	endfunction

	function automatic void predict_cache(sawcl_pkg::op_t op, logic [31:0] a,
			logic [3:0] rid, logic [31:0] d, logic [31:0] mv, logic [2:0] wi);
		int unsigned set, wrd, base, way, ln, hitway;
		logic [18:0] tg;
		logic [31:0] pre;
		bit hit;
		set = a[12:5];
		tg = a[31:13];
		wrd = a[4:2];
		base = set * NWAYS;
		hit = 0;
		hitway = 0;
		for (int i = 0; i < NWAYS; i++)
			if (!hit && valid_mem[base+i] && tag_mem[base+i] == tg) begin
				hit = 1;
				hitway = i;
			end
		if (op == sawcl_pkg::OP_READ || op == sawcl_pkg::OP_WRITE) begin
			if (hit) begin
				ln = (base + hitway) * NWORDS + wrd;
				if (op == sawcl_pkg::OP_WRITE) begin
					word_mem[ln] = d;
					dirty_mem[base+hitway] = 1;
				end
				promote(base, hitway);
				expected_beats.push_back(mk(
					(op == sawcl_pkg::OP_WRITE) ? sawcl_pkg::KIND_WRITE_HIT
						: sawcl_pkg::KIND_READ_HIT,
					a, word_mem[ln], rid, 1'b0, 1'b1));
			end else
				expected_beats.push_back(mk(sawcl_pkg::KIND_MISS, a, 32'd0, rid,
					op == sawcl_pkg::OP_WRITE, 1'b1));
			return;
		end
		fill_words[wi] = d;
		if (wi != NWORDS - 1) return;
		if (hit) way = hitway;
		else begin
			way = NWAYS;
			for (int i = NWAYS - 1; i >= 0; i--)
				if (!valid_mem[base+i]) way = i;
			if (way == NWAYS) begin
				way = 0;
				for (int i = NWAYS - 1; i >= 0; i--)
					if (rank_mem[base+i] == 0) way = i;
			end
		end
		ln = base + way;
		if (valid_mem[ln] && dirty_mem[ln]) begin
			pre = {tag_mem[ln], set[7:0], 5'd0};
			for (int w = 0; w < NWORDS; w++)
				expected_beats.push_back(mk(sawcl_pkg::KIND_WB_WORD, pre | (w << 2),
					word_mem[ln*NWORDS+w], rid, 1'b0, 1'b0));
		end
		tag_mem[ln] = tg;
		for (int w = 0; w < NWORDS; w++) word_mem[ln*NWORDS+w] = fill_words[w];
		valid_mem[ln] = 1;
		dirty_mem[ln] = (op == sawcl_pkg::OP_FILL_WRITE);
		if (op == sawcl_pkg::OP_FILL_WRITE) word_mem[ln*NWORDS+wrd] = mv;
		promote(base, way);
		expected_beats.push_back(mk(sawcl_pkg::KIND_FILLED, {a[31:5], 5'd0},
			word_mem[ln*NWORDS+wrd], rid, op == sawcl_pkg::OP_FILL_WRITE, 1'b1));
	endfunction

	always @(posedge clk) begin
		beat_t got, want;
		if (!arst_n) begin
			mismatches = 0;
			outstanding = 0;
			expected_beats.delete();
			for (int i = 0; i < NSETS * NWAYS; i++) begin
				valid_mem[i] = 0;
				dirty_mem[i] = 0;
				rank_mem[i] = 0;
			end
		end else begin
			// pop before push: a beat leaving now belongs to an earlier request
			if (rsp_valid && !rsp_stall) begin
				got = mk(sawcl_pkg::kind_t'(kind), out_address, out_data, out_request_id,
					miss_is_write, last);
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t unexpected beat kind=%0d addr=%h data=%h",
							$realtime, kind, out_address, out_data);
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%t beat differs: exp kind=%0d addr=%h data=%h id=%0d",
								$realtime, want.kind, want.addr, want.word, want.rid);
							$display("  exp mw=%b last=%b | got kind=%0d addr=%h data=%h",
								want.mw, want.lst, got.kind, got.addr, got.word);
							$display("  got id=%0d mw=%b last=%b",
								got.rid, got.mw, got.lst);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				predict_cache(sawcl_pkg::op_t'(operation), address, request_id, data,
					merge_value, word_index);
			outstanding = expected_beats.size();
		end
	end

endmodule

### tb/tb_set_assoc_writeback_cache_lru_unit.sv
// Stimulus and verdict for the set-associative write-back cache.
// Depends on sawcl_pkg, set_assoc_writeback_cache_lru_unit and sawcl_scoreboard.
module tb_set_assoc_writeback_cache_lru_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	logic [1:0]  operation = sawcl_pkg::OP_READ;
	logic [31:0] address = 0;
	logic [3:0]  request_id = 0;
	logic [31:0] data = 0;
	logic [31:0] merge_value = 0;
	logic [2:0]  word_index = 0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	logic [2:0]  kind;
	logic [31:0] out_address;
	logic [31:0] out_data;
	logic [3:0]  out_request_id;
	logic        miss_is_write;
	logic        last;
	int unsigned mismatches, outstanding;
	bit          calm = 0;
	bit          hold_req = 0;
	int unsigned sent = 0;

	set_assoc_writeback_cache_lru_unit dut (.*);
	sawcl_scoreboard u_scoreboard (.*);

	initial forever #2 clk = ~clk;

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// response side back-pressure, bursts plus one long hold
	initial begin
		int unsigned n;
		bit hold_done;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				rsp_stall <= 1;
				n = 0;
				while (n < 300) begin
					@(negedge clk);
					n++;
				end
				hold_done = 1;
				rsp_stall <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rsp_stall <= 0;
			end
		end
	end

	task automatic send_req(sawcl_pkg::op_t op, logic [31:0] a, logic [31:0] d,
			logic [31:0] mv, logic [2:0] wi);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_valid   <= 1;
		operation   <= op;
		address     <= a;
		request_id  <= 4'($urandom);
		data        <= d;
		merge_value <= mv;
		word_index  <= wi;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// eight fill words in shuffled order, the completing word last
	task automatic fill_line(sawcl_pkg::op_t op, logic [31:0] a);
		logic [2:0] order[7];
		logic [2:0] t;
		int unsigned j;
		for (int i = 0; i < 7; i++) order[i] = 3'(i);
		for (int i = 6; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		for (int i = 0; i < 7; i++) send_req(op, a, $urandom, $urandom, order[i]);
		send_req(op, a, $urandom, $urandom, 3'd7);
	endtask

	// small tag pool over two sets so that lines hit, fill and get evicted
	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return {19'($urandom_range(0, 10)), 8'($urandom_range(0, 1)), 5'($urandom)};
	endfunction

	initial begin
		logic [31:0] a;
		int unsigned r;
		repeat (4) @(negedge clk);
		arst_n = 1;

		// directed
		fill_line(sawcl_pkg::OP_FILL_READ, 32'h0000_0004);
		send_req(sawcl_pkg::OP_READ, 32'h0000_0004, 32'd0, 32'd0, 3'd0);
		send_req(sawcl_pkg::OP_WRITE, 32'h0000_000B, 32'hFFFF_FFFF, 32'd0, 3'd0);
		send_req(sawcl_pkg::OP_READ, 32'h0000_0008, 32'd0, 32'd0, 3'd0);
		send_req(sawcl_pkg::OP_READ, 32'hFFFF_FFFF, 32'd0, 32'd0, 3'd0);
		send_req(sawcl_pkg::OP_WRITE, 32'h8000_0020, 32'h0, 32'hFFFF_FFFF, 3'd7);
		send_req(sawcl_pkg::OP_FILL_WRITE, 32'h0000_0001, 32'h1234_5678,
			32'hA5A5_5A5A, 3'd3);
		// line present and dirty: written back then refilled with merge
		send_req(sawcl_pkg::OP_FILL_WRITE, 32'h0000_001E, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 3'd7);
		send_req(sawcl_pkg::OP_READ, 32'h0000_001C, 32'd0, 32'd0, 3'd0);
		send_req(sawcl_pkg::OP_FILL_READ, 32'hFFFF_FFE0, 32'd0, 32'd0, 3'd7);
		send_req(sawcl_pkg::OP_READ, 32'hFFFF_FFFC, 32'd0, 32'd0, 3'd0);

		// random
		while (sent < 280) begin
			if (sent > 120 && sent < 130) hold_req = 1;
			if (sent > 240) calm = 1;
			a = pick_addr();
			r = $urandom_range(0, 99);
			if (r < 55)
				send_req(sawcl_pkg::op_t'($urandom_range(0, 1)), a, $urandom, $urandom,
					3'($urandom));
			else if (r < 75)
				fill_line(sawcl_pkg::op_t'($urandom_range(2, 3)), a);
			else if (r < 88)
				send_req(sawcl_pkg::op_t'($urandom_range(2, 3)), a, $urandom, $urandom,
					3'd7);
			else
				send_req(sawcl_pkg::op_t'($urandom_range(2, 3)), a, $urandom, $urandom,
					3'($urandom_range(0, 6)));
		end
		req_valid <= 0;

		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
